[src/cordic_sine_cosine_assert.svh]
// Assertion macros used by the sequencer (csc_ctrl) of the sine/cosine generator.
`ifndef CORDIC_SINE_COSINE_ASSERT_SVH
`define CORDIC_SINE_COSINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csc assertion failed");

`endif

[src/csc_pkg.sv]
// Shared types, constants and the arctangent table of the sine/cosine generator.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

    // Angle units in one quadrant (90 degrees at 1/64 degree).
    localparam logic [14:0] QUARTER_UNITS = 15'd5760;

    // pi in Q2.30 split over 11520: integer part and remainder.
    localparam logic [18:0] CONV_INT  = 19'd292817;
    localparam logic [12:0] CONV_REM  = 13'd7586;
    localparam logic [12:0] CONV_HALF = 13'd5760;

    // 11520 = 256 * 45; floor(2^24 / 45) for the reciprocal divide.
    localparam logic [18:0] RECIP_45 = 19'd372827;
    localparam logic [5:0]  DIV_45   = 6'd45;

    // CORDIC gain 0.60725293 in Q2.30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032872;

    // Round-half-up offset for the Q2.30 * Q2.30 -> Q1.15 step.
    localparam logic signed [62:0] ROUND_Q45 = 63'sd17592186044416;

    // Unit vector start value, 1.0 in Q2.30.
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CONV_A,
        ST_CONV_B,
        ST_CONV_C,
        ST_INIT,
        ST_ITER,
        ST_GAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic reduce_step;
        logic conv_a;
        logic conv_b;
        logic conv_c;
        logic init_rot;
        logic iter_step;
        logic gain;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic above_quarter;
        logic iter_last;
    } status_t;

    // atan(2^-i) in Q2.30, truncated; 2^(30-i) past the stored entries.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd843314856;
            5'd1:    val = 30'd497837829;
            5'd2:    val = 30'd263043836;
            5'd3:    val = 30'd133525158;
            5'd4:    val = 30'd67021686;
            5'd5:    val = 30'd33543515;
            5'd6:    val = 30'd16775850;
            5'd7:    val = 30'd8388437;
            5'd8:    val = 30'd4194282;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048575;
            default: val = 30'd1 << (5'd30 - idx);
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[src/csc_ctrl.sv]
// Sequencing state machine and output handshake of the sine/cosine generator.
`timescale 1ns / 1ps
`default_nettype none

`include "cordic_sine_cosine_assert.svh"

module csc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output csc_pkg::cmd_t       cmd,
    input  wire csc_pkg::status_t status
);

    csc_pkg::state_t state_reg;
    csc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            csc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = csc_pkg::ST_REDUCE;
                end
            end
            csc_pkg::ST_REDUCE:
            begin
                if (status.above_quarter)
                begin
                    cmd.reduce_step = 1'b1;
                end
                else
                begin
                    state_next = csc_pkg::ST_CONV_A;
                end
            end
            csc_pkg::ST_CONV_A:
            begin
                cmd.conv_a = 1'b1;
                state_next = csc_pkg::ST_CONV_B;
            end
            csc_pkg::ST_CONV_B:
            begin
                cmd.conv_b = 1'b1;
                state_next = csc_pkg::ST_CONV_C;
            end
            csc_pkg::ST_CONV_C:
            begin
                cmd.conv_c = 1'b1;
                state_next = csc_pkg::ST_INIT;
            end
            csc_pkg::ST_INIT:
            begin
                cmd.init_rot = 1'b1;
                state_next   = csc_pkg::ST_ITER;
            end
            csc_pkg::ST_ITER:
            begin
                cmd.iter_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = csc_pkg::ST_GAIN;
                end
            end
            csc_pkg::ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = csc_pkg::ST_FINISH;
            end
            csc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = csc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !m_tready);
    assign m_tvalid       = out_valid_reg;

    `CSC_ASSERT_NEXT(a_accept_starts_reduce, clk, rst_n, s_tvalid && s_tready,
        state_reg == csc_pkg::ST_REDUCE)
    `CSC_ASSERT_IMPL(a_cmd_exclusive, clk, rst_n, 1'b1,
        ($onehot0({cmd.load_in, cmd.reduce_step, cmd.conv_a, cmd.conv_b, cmd.conv_c,
                   cmd.init_rot, cmd.iter_step, cmd.gain, cmd.out_load})))
    `CSC_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, cmd.out_load, !m_tvalid || m_tready)
    `CSC_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.out_load, m_tvalid)
    `CSC_ASSERT_NEXT(a_iter_exit, clk, rst_n,
        state_reg == csc_pkg::ST_ITER && status.iter_last, state_reg == csc_pkg::ST_GAIN)

endmodule

`default_nettype wire

[src/csc_datapath.sv]
// Angle reduction, radian conversion, CORDIC rotation and output scaling datapath.
`timescale 1ns / 1ps
`default_nettype none

module csc_datapath #(
    parameter int ITERATIONS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [14:0]      angle_degrees,
    input  wire csc_pkg::cmd_t    cmd,
    output csc_pkg::status_t      status,
    output logic signed [15:0]    sine_value,
    output logic signed [15:0]    cosine_value
);

    localparam int CNT_W = $clog2(ITERATIONS);

    // Angle reduction
    logic [14:0]              r_reg;
    logic [1:0]               quad_reg;
    logic [12:0]              r13;

    // Degree-to-radian conversion
    logic [25:0]              pa_reg;
    logic [30:0]              zb_reg;
    logic [17:0]              t_reg;
    logic [36:0]              pb_reg;
    logic [12:0]              q_reg;
    logic [12:0]              q0;
    logic [18:0]              rem;

    // Rotation
    logic signed [31:0]       x_reg;
    logic signed [31:0]       y_reg;
    logic signed [31:0]       z_reg;
    logic signed [31:0]       x_next;
    logic signed [31:0]       y_next;
    logic signed [31:0]       z_next;
    logic signed [31:0]       xs;
    logic signed [31:0]       ys;
    logic signed [31:0]       atan_val;
    logic [CNT_W-1:0]         cnt_reg;

    // Gain and output
    logic signed [62:0]       ps_reg;
    logic signed [62:0]       pc_reg;
    logic signed [62:0]       s_sum;
    logic signed [62:0]       c_sum;
    logic signed [15:0]       s_sat;
    logic signed [15:0]       c_sat;
    logic signed [15:0]       so;
    logic signed [15:0]       co;
    logic signed [15:0]       sine_reg;
    logic signed [15:0]       cosine_reg;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767)
        begin
            res = 16'sd32767;
        end
        else if (v < -18'sd32768)
        begin
            res = -16'sd32768;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [15:0] res;
        if (v == -16'sd32768)
        begin
            res = 16'sd32767;
        end
        else
        begin
            res = -v;
        end
        return res;
    endfunction

    assign r13 = r_reg[12:0];

    assign status.above_quarter = (r_reg >= csc_pkg::QUARTER_UNITS);
    assign status.iter_last     = (cnt_reg == CNT_W'(ITERATIONS - 1));

    // Reciprocal quotient is exact or one low; one compare fixes it.
    assign q0  = pb_reg[36:24];
    assign rem = {1'b0, t_reg} - ({6'd0, q0} * {13'd0, csc_pkg::DIV_45});

    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign atan_val = signed'({2'b00, csc_pkg::atan_q30(5'(cnt_reg))});

    always_comb
    begin
        if (z_reg[31])
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
    end

    assign s_sum = ps_reg + csc_pkg::ROUND_Q45;
    assign c_sum = pc_reg + csc_pkg::ROUND_Q45;
    assign s_sat = sat16(s_sum[62:45]);
    assign c_sat = sat16(c_sum[62:45]);

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                so = s_sat;
                co = c_sat;
            end
            2'd1:
            begin
                so = c_sat;
                co = neg_sat16(s_sat);
            end
            2'd2:
            begin
                so = neg_sat16(s_sat);
                co = neg_sat16(c_sat);
            end
            default:
            begin
                so = neg_sat16(c_sat);
                co = s_sat;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.init_rot)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.iter_step && !status.iter_last)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            r_reg    <= angle_degrees;
            quad_reg <= 2'd0;
        end
        if (cmd.reduce_step)
        begin
            r_reg    <= r_reg - csc_pkg::QUARTER_UNITS;
            quad_reg <= quad_reg + 2'd1;
        end
        if (cmd.conv_a)
        begin
            pa_reg <= ({13'd0, r13} * {13'd0, csc_pkg::CONV_REM}) + {13'd0, csc_pkg::CONV_HALF};
            zb_reg <= {18'd0, r13} * {12'd0, csc_pkg::CONV_INT};
        end
        if (cmd.conv_b)
        begin
            t_reg  <= pa_reg[25:8];
            pb_reg <= {19'd0, pa_reg[25:8]} * {18'd0, csc_pkg::RECIP_45};
        end
        if (cmd.conv_c)
        begin
            q_reg <= (rem >= {13'd0, csc_pkg::DIV_45}) ? q0 + 13'd1 : q0;
        end
        if (cmd.init_rot)
        begin
            x_reg <= csc_pkg::ONE_Q30;
            y_reg <= '0;
            z_reg <= signed'({1'b0, zb_reg} + {19'd0, q_reg});
        end
        if (cmd.iter_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (cmd.gain)
        begin
            ps_reg <= y_reg * signed'({1'b0, csc_pkg::GAIN_Q30});
            pc_reg <= x_reg * signed'({1'b0, csc_pkg::GAIN_Q30});
        end
        if (cmd.out_load)
        begin
            sine_reg   <= so;
            cosine_reg <= co;
        end
    end

    assign sine_value   = sine_reg;
    assign cosine_value = cosine_reg;

endmodule

`default_nettype wire

[src/cordic_sine_cosine.sv]
// Top level of the CORDIC sine/cosine generator (angle in 1/64 degree in, Q1.15 out).
// Accept to m_tvalid runs REDUCE (k = 0..5 quadrant subtractions), conversion, INIT,
// ITER, GAIN and FINISH. One item is in flight; the next is taken the cycle after the
// result is registered. ITER does one shift-add rotation per cycle, and FINISH stalls
// while the previous result still waits unread in the output register.
// Reset (rst_n low, asynchronous) empties the result register and returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module cordic_sine_cosine #(
    parameter int ITERATIONS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] angle_degrees, [15] zero
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [15:0] sine_value, [31:16] cosine_value
);

    // Command and status between the sequencer and the datapath.
    csc_pkg::cmd_t      cmd;
    csc_pkg::status_t   status;

    logic signed [15:0] sine_value;
    logic signed [15:0] cosine_value;

    // The sequencer walks each item through: quadrant reduction (one compare and
    // subtract of 90 degrees per cycle), three steps of degree-to-radian
    // conversion (multiply, reciprocal divide by 45, correction), vector load,
    // ITERATIONS micro-rotations, the gain multiply and the output mapping.
    csc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath owns the output register, so a finished item can sit there
    // while the next item is already being accepted and rotated.
    csc_datapath #(
        .ITERATIONS (ITERATIONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .angle_degrees (s_tdata[14:0]),
        .cmd           (cmd),
        .status        (status),
        .sine_value    (sine_value),
        .cosine_value  (cosine_value)
    );

    assign m_tdata = {cosine_value, sine_value};

endmodule

`default_nettype wire
